>>> hdl/csa_pkg.sv
// Shared constants, command codes and controller/datapath types for the
// contiguous store allocator. No dependencies.
`default_nettype none
package csa_pkg;

  localparam int SLOTS        = 16;
  localparam int STORE_DEPTH  = 256;
  localparam int LOADER_DEPTH = 16;
  localparam int VALUE_BITS   = 32;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int LAYER_W = 8;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 3;
  localparam int OFF_W   = 4;
  localparam int STAT_W  = 2;
  localparam int LIDX_W  = $clog2(LOADER_DEPTH);

  localparam logic [KIND_W-1:0] KIND_STAGE      = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CLR_LOADER = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FREE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLR_ALL    = 3'd5;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NO_SLOT = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_LOADER  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SEARCH, ST_COMPACT, ST_FLUSH,
    ST_GRANT, ST_PLACE, ST_FREE, ST_READ, ST_READ_OUT
  } state_e;

  typedef enum logic [1:0] {RES_NONE, RES_SLOT, RES_ALLOC, RES_READ} res_e;

  typedef struct packed {
    logic              latch;
    logic              stage;
    logic              clr_loader;
    logic              clr_all;
    logic              walk_clr;
    logic              search_step;
    logic              compact_step;
    logic              load_dst;
    logic              grant;
    logic              place_step;
    logic              free_step;
    logic              read_issue;
    logic              res_valid;
    res_e              res_kind;
    logic [STAT_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              stage_full;
    logic              bad_count;
    logic              slot_hit;
    logic              search_hit;
    logic              walk_last;
    logic              store_full;
    logic              no_slot;
    logic              place_last;
    logic              free_last;
  } stat_t;

endpackage
`default_nettype wire

>>> hdl/contiguous_store_allocator_compacting_top.sv
// Top level of the contiguous store allocator: joins the sequencer and the
// datapath. Uses csa_pkg, csa_ctrl and csa_dp.
//
// One command at a time: a beat is taken when start_i is high and busy_o low,
// and exactly one result beat follows, flagged by done_o for a single cycle;
// the receiver cannot stall it. Staging, loader clear, clear all, unknown
// kinds and commands refused at dispatch answer from the dispatch state;
// read of a held slot passes a read state and an output state; free clears
// the slot's cells one by one. Allocate walks the cell map one cell a cycle
// (first fit) until a run fits; without a fit it makes a second compaction
// pass over the whole map through the value store's single read and write
// port, then places one cell a cycle. No clearing pass after reset.
`default_nettype none
module contiguous_store_allocator_compacting_top (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  output logic               busy_o,
  input  wire [2:0]          kind_i,
  input  wire signed [31:0]  value_i,
  input  wire [4:0]          count_i,
  input  wire [7:0]          layer_i,
  input  wire [1:0]          write_mode_i,
  input  wire [3:0]          slot_i,
  input  wire [3:0]          offset_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [3:0]         slot_out_o,
  output logic [7:0]         start_out_o,
  output logic [4:0]         count_out_o,
  output logic [7:0]         layer_out_o,
  output logic [1:0]         mode_out_o,
  output logic signed [31:0] value_out_o,
  output logic               slot_busy_o
);
  import csa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  csa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  csa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (kind_i),
    .value_i     (value_i),
    .count_i     (count_i),
    .layer_i     (layer_i),
    .write_mode_i(write_mode_i),
    .slot_i      (slot_i),
    .offset_i    (offset_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .done_o      (done_o),
    .status_o    (status_o),
    .slot_out_o  (slot_out_o),
    .start_out_o (start_out_o),
    .count_out_o (count_out_o),
    .layer_out_o (layer_out_o),
    .mode_out_o  (mode_out_o),
    .value_out_o (value_out_o),
    .slot_busy_o (slot_busy_o)
  );

endmodule
`default_nettype wire

>>> hdl/csa_ctrl.sv
// Sequencer for the allocator: decodes the latched command and steps the
// datapath through search, compaction, placement, free and read. Uses csa_pkg.
`default_nettype none
module csa_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  output logic                busy_o,
  input  wire csa_pkg::stat_t stat_i,
  output csa_pkg::cmd_t       cmd_o
);
  import csa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_d = ST_IDLE;
        unique case (stat_i.kind)
          KIND_ALLOC: if (!stat_i.bad_count) state_d = ST_SEARCH;
          KIND_FREE:  if (stat_i.slot_hit) state_d = ST_FREE;
          KIND_READ:  if (stat_i.slot_hit) state_d = ST_READ;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_SEARCH: begin
        if (stat_i.search_hit) state_d = ST_GRANT;
        else if (stat_i.walk_last) state_d = ST_COMPACT;
      end
      ST_COMPACT: begin
        if (stat_i.walk_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: state_d = ST_GRANT;
      ST_GRANT: begin
        if (stat_i.store_full || stat_i.no_slot) state_d = ST_IDLE;
        else state_d = ST_PLACE;
      end
      ST_PLACE: if (stat_i.place_last) state_d = ST_IDLE;
      ST_FREE:  if (stat_i.free_last) state_d = ST_IDLE;
      ST_READ:  state_d = ST_READ_OUT;
      ST_READ_OUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_kind = RES_NONE;
    cmd_o.res_status = STATUS_OK;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: cmd_o.latch = start_i;
      ST_DISPATCH: begin
        unique case (stat_i.kind)
          KIND_STAGE: begin
            cmd_o.res_valid = 1'b1;
            if (stat_i.stage_full) cmd_o.res_status = STATUS_LOADER;
            else cmd_o.stage = 1'b1;
          end
          KIND_CLR_LOADER: begin
            cmd_o.clr_loader = 1'b1;
            cmd_o.res_valid = 1'b1;
          end
          KIND_CLR_ALL: begin
            cmd_o.clr_all = 1'b1;
            cmd_o.res_valid = 1'b1;
          end
          KIND_ALLOC: begin
            cmd_o.walk_clr = 1'b1;
            if (stat_i.bad_count) begin
              cmd_o.res_valid = 1'b1;
              cmd_o.res_status = STATUS_LOADER;
            end
          end
          KIND_FREE, KIND_READ: begin
            cmd_o.walk_clr = 1'b1;
            if (!stat_i.slot_hit) begin
              cmd_o.res_valid = 1'b1;
              cmd_o.res_kind = RES_SLOT;
            end
          end
          default: cmd_o.res_valid = 1'b1;
        endcase
      end
      ST_SEARCH: begin
        cmd_o.search_step = 1'b1;
        cmd_o.walk_clr = stat_i.walk_last && !stat_i.search_hit;
      end
      ST_COMPACT: cmd_o.compact_step = 1'b1;
      ST_FLUSH: cmd_o.load_dst = 1'b1;
      ST_GRANT: begin
        if (stat_i.store_full) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_status = STATUS_FULL;
        end else if (stat_i.no_slot) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_status = STATUS_NO_SLOT;
        end else begin
          cmd_o.grant = 1'b1;
        end
      end
      ST_PLACE: begin
        cmd_o.place_step = 1'b1;
        if (stat_i.place_last) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_kind = RES_ALLOC;
        end
      end
      ST_FREE: begin
        cmd_o.free_step = 1'b1;
        if (stat_i.free_last) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_kind = RES_SLOT;
        end
      end
      ST_READ: cmd_o.read_issue = 1'b1;
      ST_READ_OUT: begin
        cmd_o.res_valid = 1'b1;
        cmd_o.res_kind = RES_READ;
      end
      default: cmd_o.res_valid = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/csa_dp.sv
// Datapath of the allocator: loader buffer, slot table, cell-used map, value
// store memory, walk counters and the result register. Uses csa_pkg.
`default_nettype none
module csa_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire [2:0]            kind_i,
  input  wire signed [31:0]    value_i,
  input  wire [4:0]            count_i,
  input  wire [7:0]            layer_i,
  input  wire [1:0]            write_mode_i,
  input  wire [3:0]            slot_i,
  input  wire [3:0]            offset_i,
  input  wire csa_pkg::cmd_t   cmd_i,
  output csa_pkg::stat_t       stat_o,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [3:0]           slot_out_o,
  output logic [7:0]           start_out_o,
  output logic [4:0]           count_out_o,
  output logic [7:0]           layer_out_o,
  output logic [1:0]           mode_out_o,
  output logic signed [31:0]   value_out_o,
  output logic                 slot_busy_o
);
  import csa_pkg::*;

  // latched item
  logic [KIND_W-1:0]     kind_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [LAYER_W-1:0]    layer_q;
  logic [MODE_W-1:0]     mode_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [OFF_W-1:0]      off_q;

  // store state
  logic [VALUE_BITS-1:0] mem [STORE_DEPTH];
  logic [VALUE_BITS-1:0] mem_rd_q;
  logic [STORE_DEPTH-1:0] cell_used_q;
  logic [SLOTS-1:0]      slot_valid_q;
  logic [ADDR_W-1:0]     slot_start_q [SLOTS];
  logic [CNT_W-1:0]      slot_count_q [SLOTS];
  logic [LAYER_W-1:0]    slot_layer_q [SLOTS];
  logic [MODE_W-1:0]     slot_mode_q  [SLOTS];
  logic [VALUE_BITS-1:0] staged_q [LOADER_DEPTH];
  logic [CNT_W-1:0]      staged_cnt_q;

  // walk state
  logic [ADDR_W-1:0]     idx_q;
  logic [CNT_W-1:0]      run_q;
  logic [ADDR_W:0]       holes_q;
  logic [ADDR_W:0]       dst_q;
  logic [ADDR_W:0]       start_q;
  logic                  pend_wr_q;
  logic [ADDR_W-1:0]     pend_dst_q;
  logic [LIDX_W-1:0]     k_q;
  logic [SLOT_W-1:0]     gslot_q;
  logic                  rd_hit_q;

  logic                  cur_used;
  logic [CNT_W-1:0]      run_nxt;
  logic [SLOT_W-1:0]     free_idx;
  logic [ADDR_W-1:0]     place_addr;
  logic [ADDR_W:0]       free_addr;
  logic [ADDR_W:0]       read_addr;
  logic                  read_ok;
  logic [ADDR_W+1:0]     end_sum;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [VALUE_BITS-1:0] mem_wd;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_ra;

  assign cur_used   = cell_used_q[idx_q];
  assign run_nxt    = cur_used ? '0 : run_q + CNT_W'(1);
  assign place_addr = start_q[ADDR_W-1:0] + ADDR_W'(k_q);
  assign free_addr  = {1'b0, slot_start_q[slot_q]} + (ADDR_W+1)'(k_q);
  assign read_addr  = {1'b0, slot_start_q[slot_q]} + (ADDR_W+1)'(off_q);
  assign read_ok    = ({1'b0, off_q} < slot_count_q[slot_q]) &&
                      (read_addr < (ADDR_W+1)'(STORE_DEPTH));
  assign end_sum    = {1'b0, start_q} + (ADDR_W+2)'(cnt_q);

  always_comb begin
    free_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (!slot_valid_q[s]) free_idx = SLOT_W'(s);
    end
  end

  always_comb begin
    stat_o.kind       = kind_q;
    stat_o.stage_full = staged_cnt_q >= CNT_W'(LOADER_DEPTH);
    stat_o.bad_count  = (cnt_q == '0) || (cnt_q > CNT_W'(LOADER_DEPTH)) ||
                        (cnt_q > staged_cnt_q);
    stat_o.slot_hit   = slot_valid_q[slot_q];
    stat_o.search_hit = (run_nxt == cnt_q);
    stat_o.walk_last  = (idx_q == ADDR_W'(STORE_DEPTH - 1));
    stat_o.store_full = end_sum > (ADDR_W+2)'(STORE_DEPTH);
    stat_o.no_slot    = &slot_valid_q;
    stat_o.place_last = ({1'b0, k_q} == cnt_q - CNT_W'(1));
    stat_o.free_last  = ({1'b0, k_q} == slot_count_q[slot_q] - CNT_W'(1));
  end

  // one write and one read port; a compaction move is written back from mem_rd_q to pend_dst_q
  assign mem_we = pend_wr_q | cmd_i.place_step;
  assign mem_wa = pend_wr_q ? pend_dst_q : place_addr;
  assign mem_wd = pend_wr_q ? mem_rd_q : staged_q[k_q];
  assign mem_re = cmd_i.compact_step | cmd_i.read_issue;
  assign mem_ra = cmd_i.compact_step ? idx_q : read_addr[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q  <= kind_i;
      value_q <= value_i;
      cnt_q   <= count_i;
      layer_q <= layer_i;
      mode_q  <= write_mode_i;
      slot_q  <= slot_i;
      off_q   <= offset_i;
    end
    if (cmd_i.stage) staged_q[staged_cnt_q[LIDX_W-1:0]] <= value_q;
    if (cmd_i.walk_clr) begin
      idx_q   <= '0;
      run_q   <= '0;
      holes_q <= '0;
      dst_q   <= '0;
      k_q     <= '0;
    end else if (cmd_i.search_step) begin
      idx_q <= idx_q + ADDR_W'(1);
      run_q <= run_nxt;
      if (run_nxt == cnt_q) begin
        start_q <= {1'b0, idx_q} + (ADDR_W+1)'(1) - (ADDR_W+1)'(cnt_q);
      end
    end else if (cmd_i.compact_step) begin
      idx_q   <= idx_q + ADDR_W'(1);
      holes_q <= holes_q + (ADDR_W+1)'(!cur_used);
      dst_q   <= dst_q + (ADDR_W+1)'(cur_used);
    end else if (cmd_i.grant) begin
      k_q <= '0;
    end else if (cmd_i.place_step || cmd_i.free_step) begin
      k_q <= k_q + LIDX_W'(1);
    end
    if (cmd_i.load_dst) start_q <= dst_q;
    pend_dst_q <= dst_q[ADDR_W-1:0];
    if (cmd_i.read_issue) rd_hit_q <= read_ok;
    for (int s = 0; s < SLOTS; s++) begin
      if (cmd_i.compact_step && slot_valid_q[s] && slot_start_q[s] == idx_q) begin
        slot_start_q[s] <= slot_start_q[s] - holes_q[ADDR_W-1:0];
      end
    end
    if (cmd_i.grant) begin
      gslot_q                <= free_idx;
      slot_start_q[free_idx] <= start_q[ADDR_W-1:0];
      slot_count_q[free_idx] <= cnt_q;
      slot_layer_q[free_idx] <= layer_q;
      slot_mode_q[free_idx]  <= mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_cnt_q <= '0;
      cell_used_q  <= '0;
      slot_valid_q <= '0;
      pend_wr_q    <= 1'b0;
      done_o       <= 1'b0;
    end else begin
      pend_wr_q <= cmd_i.compact_step & cur_used;
      done_o    <= cmd_i.res_valid;
      if (cmd_i.stage) staged_cnt_q <= staged_cnt_q + CNT_W'(1);
      if (cmd_i.clr_loader) staged_cnt_q <= '0;
      if (cmd_i.clr_all) begin
        cell_used_q  <= '0;
        slot_valid_q <= '0;
      end
      // used cells pack below dst; dst never passes the walk index
      if (cmd_i.compact_step && cur_used && dst_q[ADDR_W-1:0] != idx_q) begin
        cell_used_q[dst_q[ADDR_W-1:0]] <= 1'b1;
        cell_used_q[idx_q]             <= 1'b0;
      end
      if (cmd_i.grant) slot_valid_q[free_idx] <= 1'b1;
      if (cmd_i.place_step) cell_used_q[place_addr] <= 1'b1;
      if (cmd_i.free_step) begin
        if (free_addr < (ADDR_W+1)'(STORE_DEPTH)) begin
          cell_used_q[free_addr[ADDR_W-1:0]] <= 1'b0;
        end
        if (stat_o.free_last) slot_valid_q[slot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_valid) begin
      status_o    <= cmd_i.res_status;
      slot_out_o  <= '0;
      start_out_o <= '0;
      count_out_o <= '0;
      layer_out_o <= '0;
      mode_out_o  <= '0;
      value_out_o <= '0;
      slot_busy_o <= 1'b0;
      case (cmd_i.res_kind)
        RES_SLOT: slot_out_o <= slot_q;
        RES_ALLOC: begin
          slot_out_o  <= gslot_q;
          start_out_o <= slot_start_q[gslot_q];
          count_out_o <= slot_count_q[gslot_q];
          layer_out_o <= slot_layer_q[gslot_q];
          mode_out_o  <= slot_mode_q[gslot_q];
          value_out_o <= staged_q[0];
          slot_busy_o <= 1'b1;
        end
        RES_READ: begin
          slot_out_o  <= slot_q;
          start_out_o <= slot_start_q[slot_q];
          count_out_o <= slot_count_q[slot_q];
          layer_out_o <= slot_layer_q[slot_q];
          mode_out_o  <= slot_mode_q[slot_q];
          value_out_o <= rd_hit_q ? mem_rd_q : '0;
          slot_busy_o <= 1'b1;
        end
        default: slot_busy_o <= 1'b0;
      endcase
    end
  end

  a_place_free_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.place_step |-> !cell_used_q[place_addr])
    else $error("placing over a used cell");

  a_dst_behind_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.compact_step |-> dst_q <= {1'b0, idx_q})
    else $error("compaction target ahead of walk");

  a_loader_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    staged_cnt_q <= CNT_W'(LOADER_DEPTH))
    else $error("loader count out of range");

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("back-to-back result beats");

endmodule
`default_nettype wire
